/* design/spq_pkg.sv */
`timescale 1ns / 1ps
package spq_pkg;

    localparam int CAPACITY = 64;
    localparam int TAG_BITS = 16;
    localparam int TYPE_BITS = 8;
    localparam int PRIO_BITS = 32;
    localparam int STATUS_BITS = 3;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam int IN_FIELD_W = TAG_BITS + TYPE_BITS + PRIO_BITS;
    localparam int IN_DATA_W = ((IN_FIELD_W + 7) / 8) * 8;
    localparam int OUT_FIELD_W = CNT_W + TAG_BITS + TYPE_BITS + PRIO_BITS;
    localparam int OUT_DATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    localparam logic [STATUS_BITS-1:0] ST_OK = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_DUP = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_NULL = 3'd4;

    typedef struct packed {
        logic signed [PRIO_BITS-1:0] prio;
        logic [TYPE_BITS-1:0] item_type;
        logic [TAG_BITS-1:0] tag;
    } entry_t;

    typedef struct packed {
        logic capture;
        logic insert;
        logic remove;
    } cell_cmd_t;

endpackage

/* design/stable_priority_queue_unit.sv */
`timescale 1ns / 1ps
// Stable sorted priority queue built as a row of shifting cells.
// Input stream: s_tuser carries the operation (insert or remove lowest),
// s_tdata carries tag, type and signed priority of an inserted item.
// Output stream: one result per operation; m_tuser carries the status,
// m_tdata the count after the operation and the removed entry (zero on
// inserts and on rejected operations).
// In the transfer cycle every cell compares its entry with the item and
// registers the outcome; in the commit state that follows, the row shifts
// right (insert) or left (remove) and the result is registered. A new
// item is taken only in the idle state, so the next item waits until the
// previous one has committed. The cell compare is split from the row-wide
// duplicate OR and shift by the registered match and place flags.
// Reset empties the queue; cell contents are not cleared, only the count.
// While the receiver stalls a result, the next item is still taken and
// compared, and its commit waits until the output register is free.
module stable_priority_queue_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [spq_pkg::IN_DATA_W-1:0]     s_tdata,  // item_tag, item_type, priority_req
    input  logic                              s_tuser,  // kind
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [spq_pkg::OUT_DATA_W-1:0]    m_tdata,  // count, out_tag, out_type, out_priority
    output logic [spq_pkg::STATUS_BITS-1:0]   m_tuser   // status
);
    import spq_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_COMMIT = 1'b1;

    logic                   state_reg;
    logic                   state_next;
    logic                   kind_reg;
    entry_t                 req_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   m_tvalid_reg;
    logic [OUT_DATA_W-1:0]  m_tdata_reg;
    logic [STATUS_BITS-1:0] m_tuser_reg;

    entry_t                 cmp_entry;
    entry_t                 cell_entry [CAPACITY];
    logic [CAPACITY-1:0]    cell_match;
    logic [CAPACITY-1:0]    cell_place;
    cell_cmd_t              cmd;
    logic                   accept;
    logic                   commit;
    logic                   dup;
    logic                   full;
    logic                   ins_ok;
    logic                   rem_ok;
    logic [STATUS_BITS-1:0] status;
    entry_t                 out_entry;

    assign cmp_entry = entry_t'(s_tdata[IN_FIELD_W-1:0]);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept = s_tvalid && s_tready;
    assign commit = (state_reg == ST_COMMIT) && (!m_tvalid_reg || m_tready);

    assign dup = |cell_match;
    assign full = (count_reg == CNT_W'(CAPACITY));
    assign ins_ok = (kind_reg == KIND_INSERT) && (req_reg.tag != '0) && !dup && !full;
    assign rem_ok = (kind_reg == KIND_REMOVE) && (count_reg != '0);

    assign cmd.capture = accept;
    assign cmd.insert = commit && ins_ok;
    assign cmd.remove = commit && rem_ok;

    always_comb
    begin
        if (kind_reg == KIND_REMOVE)
        begin
            status = (count_reg == '0) ? ST_EMPTY : ST_OK;
        end
        else if (req_reg.tag == '0)
        begin
            status = ST_NULL;
        end
        else if (dup)
        begin
            status = ST_DUP;
        end
        else if (full)
        begin
            status = ST_FULL;
        end
        else
        begin
            status = ST_OK;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.remove)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign out_entry = rem_ok ? cell_entry[0] : '0;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            entry_t left_entry;
            entry_t right_entry;
            logic   left_place;
            if (i == 0)
            begin : g_first
                assign left_entry = '0;
                assign left_place = 1'b0;
            end
            else
            begin : g_inner
                assign left_entry = cell_entry[i-1];
                assign left_place = cell_place[i-1];
            end
            if (i == CAPACITY - 1)
            begin : g_last
                assign right_entry = '0;
            end
            else
            begin : g_body
                assign right_entry = cell_entry[i+1];
            end

            spq_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (cmd),
                .cmp_entry   (cmp_entry),
                .new_entry   (req_reg),
                .occupied    (count_reg > CNT_W'(i)),
                .left_entry  (left_entry),
                .left_place  (left_place),
                .right_entry (right_entry),
                .entry       (cell_entry[i]),
                .match       (cell_match[i]),
                .place       (cell_place[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (commit)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= s_tuser;
            req_reg <= cmp_entry;
        end
        if (commit)
        begin
            m_tuser_reg <= status;
            m_tdata_reg <= OUT_DATA_W'({out_entry, count_next});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("queue count exceeds capacity");

    a_no_take_in_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMMIT) |-> !s_tready)
        else $error("item taken while previous one is pending");

    a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && rem_ok) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("remove did not drop the count");

    a_reject_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && !ins_ok && !rem_ok) |=> $stable(count_reg))
        else $error("rejected operation changed the count");
`endif

endmodule

/* design/spq_cell.sv */
`timescale 1ns / 1ps
module spq_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  spq_pkg::cell_cmd_t cmd,
    input  spq_pkg::entry_t   cmp_entry,
    input  spq_pkg::entry_t   new_entry,
    input  logic              occupied,
    input  spq_pkg::entry_t   left_entry,
    input  logic              left_place,
    input  spq_pkg::entry_t   right_entry,
    output spq_pkg::entry_t   entry,
    output logic              match,
    output logic              place
);
    import spq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   match_reg;
    logic   place_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.insert)
        begin
            if (left_place)
            begin
                entry_next = left_entry;
            end
            else if (place_reg)
            begin
                entry_next = new_entry;
            end
        end
        else if (cmd.remove)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    // compare against the incoming item while it is captured
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
            place_reg <= 1'b0;
        end
        else if (cmd.capture)
        begin
            match_reg <= occupied && (entry_reg.tag == cmp_entry.tag);
            place_reg <= !occupied || (entry_reg.prio > cmp_entry.prio);
        end
    end

    assign entry = entry_reg;
    assign match = match_reg;
    assign place = place_reg;

endmodule

/* tb/stable_priority_queue_unit_tb.sv */
`timescale 1ns / 1ps
module stable_priority_queue_unit_tb;

    import spq_pkg::*;

    localparam int TOTAL_RANDOM = 1800;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD = 300;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        logic                        kind;
        logic [TAG_BITS-1:0]         tag;
        logic [TYPE_BITS-1:0]        item_type;
        logic signed [PRIO_BITS-1:0] prio;
        bit                          wait_empty;
    } queue_op_t;

    typedef struct {
        logic [STATUS_BITS-1:0]      status;
        logic [CNT_W-1:0]            count;
        logic [TAG_BITS-1:0]         tag;
        logic [TYPE_BITS-1:0]        item_type;
        logic signed [PRIO_BITS-1:0] prio;
    } queue_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [IN_DATA_W-1:0]     s_tdata = '0;
    logic                     s_tuser = 1'b0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]    m_tdata;
    logic [STATUS_BITS-1:0]   m_tuser;

    queue_op_t     pending_ops[$];
    queue_result_t expected_results[$];
    entry_t        queued_entries[$];

    int  n_accepted = 0;
    int  total_ops = 0;
    int  error_count = 0;
    int  cycle_count = 0;
    int  hold_left = 0;
    bit  long_hold_done = 0;

    stable_priority_queue_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic add_op(input logic kind, input logic [TAG_BITS-1:0] tag,
                          input logic [TYPE_BITS-1:0] item_type,
                          input logic signed [PRIO_BITS-1:0] prio, input bit wait_empty);
        queue_op_t op;
        op.kind = kind;
        op.tag = tag;
        op.item_type = item_type;
        op.prio = prio;
        op.wait_empty = wait_empty;
        pending_ops.push_back(op);
    endtask

    task automatic add_remove(input bit wait_empty);
        add_op(KIND_REMOVE, TAG_BITS'($urandom), TYPE_BITS'($urandom), $urandom, wait_empty);
    endtask

    // Apply one operation to the sorted shadow queue and log its result.
    task automatic apply_queue_op(input logic kind, input logic [TAG_BITS-1:0] tag,
                                  input logic [TYPE_BITS-1:0] item_type,
                                  input logic signed [PRIO_BITS-1:0] prio);
        queue_result_t r;
        entry_t        e;
        int            pos;
        bit            dup;
        r.status = ST_OK;
        r.tag = '0;
        r.item_type = '0;
        r.prio = '0;
        dup = 0;
        if (kind == KIND_INSERT)
        begin
            foreach (queued_entries[i])
                if (queued_entries[i].tag == tag)
                    dup = 1;
            if (tag == '0)
                r.status = ST_NULL;
            else if (dup)
                r.status = ST_DUP;
            else if (queued_entries.size() >= CAPACITY)
                r.status = ST_FULL;
            else
            begin
                pos = 0;
                while (pos < queued_entries.size() && queued_entries[pos].prio <= prio)
                    pos++;
                e.tag = tag;
                e.item_type = item_type;
                e.prio = prio;
                queued_entries.insert(pos, e);
            end
        end
        else if (queued_entries.size() == 0)
            r.status = ST_EMPTY;
        else
        begin
            e = queued_entries.pop_front();
            r.tag = e.tag;
            r.item_type = e.item_type;
            r.prio = e.prio;
        end
        r.count = CNT_W'(queued_entries.size());
        expected_results.push_back(r);
    endtask

    function automatic int sender_idle_pct();
        if (n_accepted < total_ops / 3)
            return 34;
        else if (n_accepted < 2 * total_ops / 3)
            return 82;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (n_accepted < total_ops / 3)
            return 82;
        else if (n_accepted < 2 * total_ops / 3)
            return 34;
        return 0;
    endfunction

    // Driver: predict on each accepted transfer, then offer the next item.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                apply_queue_op(s_tuser, s_tdata[TAG_BITS-1:0],
                               s_tdata[TAG_BITS +: TYPE_BITS],
                               s_tdata[TAG_BITS+TYPE_BITS +: PRIO_BITS]);
                n_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_ops.size() != 0
                    && !(pending_ops[0].wait_empty && expected_results.size() != 0)
                    && $urandom_range(99) >= sender_idle_pct())
                begin
                    s_tvalid <= 1'b1;
                    s_tuser <= pending_ops[0].kind;
                    s_tdata <= {pending_ops[0].prio, pending_ops[0].item_type,
                                pending_ops[0].tag};
                    void'(pending_ops.pop_front());
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure plus one long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (!long_hold_done && n_accepted >= total_ops / 6)
            begin
                long_hold_done = 1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= receiver_idle_pct());
        end
    end

    // Monitor: compare each result transfer with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", m_tdata, 0);
            else
            begin
                if (m_tuser != expected_results[0].status)
                    report_mismatch("status", m_tuser, expected_results[0].status);
                if (m_tdata[CNT_W-1:0] != expected_results[0].count)
                    report_mismatch("count", m_tdata[CNT_W-1:0], expected_results[0].count);
                if (m_tdata[CNT_W +: TAG_BITS] != expected_results[0].tag)
                    report_mismatch("out_tag", m_tdata[CNT_W +: TAG_BITS],
                                    expected_results[0].tag);
                if (m_tdata[CNT_W+TAG_BITS +: TYPE_BITS] != expected_results[0].item_type)
                    report_mismatch("out_type", m_tdata[CNT_W+TAG_BITS +: TYPE_BITS],
                                    expected_results[0].item_type);
                if (m_tdata[CNT_W+TAG_BITS+TYPE_BITS +: PRIO_BITS] != expected_results[0].prio)
                    report_mismatch("out_priority",
                                    m_tdata[CNT_W+TAG_BITS+TYPE_BITS +: PRIO_BITS],
                                    expected_results[0].prio);
                void'(expected_results.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int mode;
        int seg_len;
        int ins_pct;
        int r;
        logic [TAG_BITS-1:0] tag;
        logic signed [PRIO_BITS-1:0] prio;

        // empty remove, null tag, field extremes, duplicate, equal-priority order
        add_remove(0);
        add_op(KIND_INSERT, '0, 8'h5A, 32'sd7, 0);
        add_op(KIND_INSERT, 16'hFFFF, 8'hFF, 32'sh7FFFFFFF, 0);
        add_op(KIND_INSERT, 16'h0001, 8'h00, 32'sh80000000, 0);
        add_op(KIND_INSERT, 16'hFFFF, 8'h11, 32'sd0, 0);
        add_op(KIND_INSERT, 16'h0002, 8'hA1, 32'sd5, 0);
        add_op(KIND_INSERT, 16'h0003, 8'hA2, 32'sd5, 0);
        add_op(KIND_INSERT, 16'h0004, 8'hA3, 32'sd5, 0);
        add_op(KIND_INSERT, 16'h8000, 8'h80, -32'sd1, 0);
        add_op(KIND_INSERT, 16'h7FFF, 8'h7F, 32'sd0, 0);
        add_op(KIND_INSERT, 16'h0005, 8'hA4, 32'sd5, 0);
        for (int i = 0; i < 10; i++)
            add_remove(0);

        // fill to capacity, overflow, then drain past empty
        add_op(KIND_INSERT, 16'h0100, 8'h01, 32'sd3, 1);
        for (int i = 1; i < CAPACITY + 4; i++)
            add_op(KIND_INSERT, TAG_BITS'(16'h0100 + i), TYPE_BITS'($urandom),
                   $urandom_range(6) - 3, 0);
        for (int i = 0; i < CAPACITY + 2; i++)
            add_remove(0);

        while (pending_ops.size() < TOTAL_RANDOM + 25)
        begin
            mode = $urandom_range(2);
            seg_len = $urandom_range(120, 20);
            ins_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
            for (int i = 0; i < seg_len; i++)
            begin
                if ($urandom_range(99) < ins_pct)
                begin
                    r = $urandom_range(99);
                    if (r < 3)
                        tag = '0;
                    else if (r < 25)
                        tag = TAG_BITS'($urandom_range(40, 1));
                    else
                        tag = TAG_BITS'($urandom);
                    r = $urandom_range(99);
                    if (r < 40)
                        prio = $urandom_range(6) - 3;
                    else if (r < 50)
                    begin
                        case ($urandom_range(3))
                            0: prio = 32'sh80000000;
                            1: prio = 32'sh7FFFFFFF;
                            2: prio = -32'sd1;
                            default: prio = 32'sd0;
                        endcase
                    end
                    else
                        prio = $urandom;
                    add_op(KIND_INSERT, tag, TYPE_BITS'($urandom), prio,
                           pending_ops.size() == TOTAL_RANDOM / 2);
                end
                else
                    add_remove(pending_ops.size() == TOTAL_RANDOM / 2);
            end
        end
        total_ops = pending_ops.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_ops.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
